// File: rtl/pss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg
// types and constants shared by the pair sum search block
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int IDX_W = 10;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } pss_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
  } pss_out_t;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PASS,
    S_MRD,
    S_MCMP,
    S_COPY_RD,
    S_COPY_WR,
    S_WALK_RD,
    S_WALK_CMP,
    S_DONE
  } pss_state_t;

  // compare unit result
  typedef struct packed {
    logic lt;
    logic eq;
  } pss_cmp_t;

endpackage

// File: rtl/pss_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_cmp
// shared 33-bit add and signed compare unit
// ----------------------------------------------------------------------------
module pss_cmp import pss_pkg::*; (
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic               sum_mode,
  input  logic signed [31:0] goal,
  output pss_cmp_t           res
);
  logic signed [32:0] lhs;
  logic signed [32:0] rhs;

  always_comb begin
    if (sum_mode) begin
      lhs = 33'(a) + 33'(b);
      rhs = 33'(goal);
    end else begin
      lhs = 33'(a);
      rhs = 33'(b);
    end
    res.lt = lhs < rhs;
    res.eq = lhs == rhs;
  end
endmodule

// File: rtl/pair_sum_search.sv
`timescale 1ns / 1ps
// sequence: loading takes one transfer per item; after the last item a merge sort runs
// ceil(log2 n) passes (a read and a compare per merged element, a read and a write per copied
// element, then a pass step), then a walk of a read and a compare per step, then the result
// throughput: one item per cycle while loading, then the sequencer is busy until the
// result is taken; all work goes through one compare unit and registered memory reads
// reset: synchronous, clears the sequencer, counts and target_sum; the stores are not cleared
// ----------------------------------------------------------------------------
// pair_sum_search
// loads a data set, merge sorts it through a scratch bank, then runs a two pointer search
// ----------------------------------------------------------------------------
module pair_sum_search import pss_pkg::*; #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  pss_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pss_out_t           out_data
);
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = AW + 1;

  // two banks: each merge pass writes bank b, which is then copied back to bank a
  logic signed [31:0] val_a [MAX_ITEMS];
  logic [IDX_W-1:0]   idx_a [MAX_ITEMS];
  logic signed [31:0] val_b [MAX_ITEMS];
  logic [IDX_W-1:0]   idx_b [MAX_ITEMS];

  logic signed [31:0] target_sum;
  pss_state_t state, state_next;
  logic [CW-1:0] item_count;
  logic overflow_seen;
  logic [CW-1:0] width, mid, hi, pa, pb, pk;
  logic [CW-1:0] pi, pj;
  logic signed [31:0] ra_v, rb_v;
  logic [IDX_W-1:0] ra_i, rb_i;
  pss_out_t result;
  pss_cmp_t cmp;
  logic sum_mode;

  // memory read and write controls
  logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic wr_b, wr_a;
  logic signed [31:0] wr_v;
  logic [IDX_W-1:0] wr_i;

  pss_cmp u_cmp (
    .a(ra_v), .b(rb_v), .sum_mode(sum_mode), .goal(target_sum), .res(cmp)
  );

  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_DONE);
  assign out_data  = result;
  assign sum_mode  = (state == S_WALK_CMP);

  wire load_xfer = in_valid && !in_stall;
  wire take_a = (pa < mid) && ((pb >= hi) || cmp.lt || cmp.eq);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (cfg_we) begin
      target_sum <= cfg_data;
    end
  end

  // bank a: load and merge result writes after copy, read during merge and walk
  always_ff @(posedge clk) begin
    if (wr_a) begin
      val_a[wr_addr] <= wr_v;
      idx_a[wr_addr] <= wr_i;
    end
    ra_v <= val_a[rd_addr_a];
    ra_i <= idx_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      val_b[wr_addr] <= wr_v;
      idx_b[wr_addr] <= wr_i;
    end
  end

  // second read: bank a for the b side of a merge and for pj in the walk, bank b during the copy
  always_ff @(posedge clk) begin
    rb_v <= (state == S_COPY_RD) ? val_b[rd_addr_b] : val_a[rd_addr_b];
    rb_i <= (state == S_COPY_RD) ? idx_b[rd_addr_b] : idx_a[rd_addr_b];
  end

  always_comb begin
    rd_addr_a = pa[AW-1:0];
    rd_addr_b = pb[AW-1:0];
    wr_addr   = pk[AW-1:0];
    wr_a = 1'b0;
    wr_b = 1'b0;
    wr_v = ra_v;
    wr_i = ra_i;
    unique case (state)
      S_LOAD: begin
        wr_addr = item_count[AW-1:0];
        wr_a = load_xfer && (item_count < CW'(MAX_ITEMS));
        wr_v = in_data.value;
        wr_i = IDX_W'(item_count);
      end
      S_MCMP: begin
        wr_b = 1'b1;
        wr_v = take_a ? ra_v : rb_v;
        wr_i = take_a ? ra_i : rb_i;
      end
      S_COPY_RD: begin
        rd_addr_b = pk[AW-1:0];
      end
      S_COPY_WR: begin
        wr_a = 1'b1;
        wr_v = rb_v;
        wr_i = rb_i;
      end
      S_WALK_RD, S_WALK_CMP: begin
        rd_addr_a = pi[AW-1:0];
        rd_addr_b = pj[AW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:     if (load_xfer && in_data.last) state_next = S_PASS;
      S_PASS: begin
        if (overflow_seen || item_count < CW'(2)) state_next = S_DONE;
        else if ({1'b0, width} < {1'b0, item_count}) state_next = S_MRD;
        else state_next = S_WALK_RD;
      end
      S_MRD:      state_next = S_MCMP;
      S_MCMP: begin
        if (pk + CW'(1) >= hi) begin
          if ({1'b0, hi} >= {1'b0, item_count}) state_next = S_COPY_RD;
          else state_next = S_MRD;
        end else state_next = S_MRD;
      end
      S_COPY_RD:  state_next = S_COPY_WR;
      S_COPY_WR:  state_next = (pk + CW'(1) >= item_count) ? S_PASS : S_COPY_RD;
      S_WALK_RD:  state_next = (pi < pj) ? S_WALK_CMP : S_DONE;
      S_WALK_CMP: state_next = cmp.eq ? S_DONE : S_WALK_RD;
      S_DONE:     if (!out_stall) state_next = S_LOAD;
      default:    state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // run bounds for a merge starting at a given lo
  function automatic logic [CW:0] clampn(input logic [CW:0] x, input logic [CW-1:0] n);
    clampn = (x < {1'b0, n}) ? x : {1'b0, n};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      overflow_seen <= 1'b0;
      width         <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (load_xfer) begin
            if (item_count < CW'(MAX_ITEMS)) item_count <= item_count + CW'(1);
            else overflow_seen <= 1'b1;
          end
          width <= CW'(1);
          pa <= '0;
          pk <= '0;
          mid <= CW'(clampn({1'b0, CW'(1)}, item_count));
          result <= '{ST_NONE, '0, '0};
        end
        S_PASS: begin
          if (overflow_seen) result.status <= ST_OVERFLOW;
          pa <= '0;
          pk <= '0;
          pb <= CW'(clampn({1'b0, width}, item_count));
          mid <= CW'(clampn({1'b0, width}, item_count));
          hi <= CW'(clampn({1'b0, width} << 1, item_count));
          pi <= '0;
          pj <= item_count - CW'(1);
        end
        S_MRD: ;
        S_MCMP: begin
          pk <= pk + CW'(1);
          if (pk + CW'(1) >= hi) begin
            pa <= hi;
            pb <= CW'(clampn({1'b0, hi} + {1'b0, width}, item_count));
            mid <= CW'(clampn({1'b0, hi} + {1'b0, width}, item_count));
            hi <= CW'(clampn({1'b0, hi} + ({1'b0, width} << 1), item_count));
            if ({1'b0, hi} >= {1'b0, item_count}) pk <= '0;
          end else if (take_a) pa <= pa + CW'(1);
          else pb <= pb + CW'(1);
        end
        S_COPY_RD: ;
        S_COPY_WR: begin
          pk <= pk + CW'(1);
          if (pk + CW'(1) >= item_count) width <= width << 1;
        end
        S_WALK_RD: ;
        S_WALK_CMP: begin
          if (cmp.eq) result <= '{ST_FOUND, ra_i, rb_i};
          else if (cmp.lt) pi <= pi + CW'(1);
          else pj <= pj - CW'(1);
        end
        S_DONE: begin
          if (!out_stall) begin
            item_count    <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_stall_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !in_stall)
    else $error("input stalled while loading");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> (item_count == '0 && !overflow_seen))
    else $error("data set not cleared after result");
  a_overflow_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow_seen) |-> (out_data.status == ST_OVERFLOW))
    else $error("overflow not reported");
endmodule
